>>> hdl/assert_macros.svh
// assertion macros used by the list module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// clocked check, off while reset is held
`define PIDL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also runs during reset
`define PIDL_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PIDL_ASSERT(label, clk, rst_n, prop, msg)
`define PIDL_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

>>> hdl/pidl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pidl_pkg;

    // field widths
    localparam int CMD_W   = 3;
    localparam int VAL_W   = 32;
    localparam int POS_W   = 8;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    // cell index width, covers the largest list size
    localparam int CAP_MAX    = 64;
    localparam int CELL_IDX_W = $clog2(CAP_MAX);

    // commands
    localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_POS   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_BACK  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DEL_POS   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_DUMP      = 3'd6;

    // result status
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

    // cell operations
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_ROTATE = 2'd3
    } t_cell_op;

    // broadcast to every cell of the chain
    typedef struct packed {
        t_cell_op                op;
        logic [CELL_IDX_W-1:0]   idx;
    } t_cell_ctl;

endpackage
`default_nettype wire

>>> hdl/pidl_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module pidl_cell #(
    parameter int IDX = 0
) (
    input  wire                                  i_clk,
    input  wire pidl_pkg::t_cell_ctl             i_ctl,
    input  wire logic signed [pidl_pkg::VAL_W-1:0] i_value,
    input  wire logic signed [pidl_pkg::VAL_W-1:0] i_left,
    input  wire logic signed [pidl_pkg::VAL_W-1:0] i_right,
    input  wire logic signed [pidl_pkg::VAL_W-1:0] i_head,
    output logic signed [pidl_pkg::VAL_W-1:0]      o_data
);

    localparam logic [pidl_pkg::CELL_IDX_W-1:0] MY_IDX = pidl_pkg::CELL_IDX_W'(IDX);

    logic signed [pidl_pkg::VAL_W-1:0] r_data;
    logic signed [pidl_pkg::VAL_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        unique case (i_ctl.op)
            pidl_pkg::OP_INSERT: begin
                // open a gap at idx, cells above take the left neighbor
                if (MY_IDX == i_ctl.idx) begin
                    n_data = i_value;
                end else if (MY_IDX > i_ctl.idx) begin
                    n_data = i_left;
                end
            end
            pidl_pkg::OP_DELETE: begin
                if (MY_IDX >= i_ctl.idx) begin
                    n_data = i_right;
                end
            end
            pidl_pkg::OP_ROTATE: begin
                // idx is the tail, which takes the old head
                if (MY_IDX == i_ctl.idx) begin
                    n_data = i_head;
                end else begin
                    n_data = i_right;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule
`default_nettype wire

>>> hdl/positional_insert_delete_list.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  dir  tdata (low bit up)                 tuser        tlast
// s_axis   in   value[31:0], position[39:32]       cmd[2:0]     -
// m_axis   out  entry_count[4:0], entry_value      status[1:0]  last
//               [36:5], zero [39:37]
//
// on an accepted edit item every cell shifts at once and the
// single result sits in the output register on the next cycle
// a dump of n entries emits the n entries after the command, one
// rotation of the chain per emitted entry, ending back in list order
// s_axis_tready is low during a dump and while a held result is not taken
// i_rst_n (sync, active low) clears fill, dump state and output valid only
`include "assert_macros.svh"
module positional_insert_delete_list #(
    parameter int CAPACITY = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [39:0] s_axis_tdata,   // value[31:0], position[39:32]
    input  wire  [2:0]  s_axis_tuser,   // cmd[2:0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // entry_count[4:0], entry_value[36:5], zero
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    output logic        m_axis_tlast
);

    localparam int FILL_W = $clog2(CAPACITY + 1);
    localparam int IW     = pidl_pkg::CELL_IDX_W;
    localparam int VW     = pidl_pkg::VAL_W;

    // input fields
    logic [pidl_pkg::CMD_W-1:0] in_cmd;
    logic signed [VW-1:0]       in_value;
    logic [pidl_pkg::POS_W-1:0] in_pos;
    assign in_cmd   = s_axis_tuser;
    assign in_value = s_axis_tdata[31:0];
    assign in_pos   = s_axis_tdata[39:32];

    // control state
    logic              r_out_valid, n_out_valid;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_dumping, n_dumping;
    logic [FILL_W-1:0] r_dump_idx, n_dump_idx;

    // output payload
    logic [pidl_pkg::STAT_W-1:0]  r_status, n_status;
    logic [pidl_pkg::COUNT_W-1:0] r_count, n_count;
    logic signed [VW-1:0]         r_value, n_value;
    logic                         r_last, n_last;

    // chain of cells
    pidl_pkg::t_cell_ctl  cell_ctl;
    logic signed [VW-1:0] w_cell [CAPACITY];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic signed [VW-1:0] w_left;
            logic signed [VW-1:0] w_right;
            if (gi == 0) begin : g_first
                assign w_left = in_value;
            end else begin : g_mid_l
                assign w_left = w_cell[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign w_right = w_cell[gi];
            end else begin : g_mid_r
                assign w_right = w_cell[gi+1];
            end
            pidl_cell #(
                .IDX(gi)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (cell_ctl),
                .i_value (in_value),
                .i_left  (w_left),
                .i_right (w_right),
                .i_head  (w_cell[0]),
                .o_data  (w_cell[gi])
            );
        end
    endgenerate

    // handshake
    logic out_free;
    logic in_acc;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_dumping && out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // list checks, done on 9 bits so fill+1 never wraps
    logic       is_full;
    logic       is_empty;
    logic [8:0] fill_ext;
    logic       pos_ok_ins;
    logic       pos_ok_del;
    logic [7:0] fill_m1;
    logic [7:0] fill_b;
    logic [7:0] pos_m1;
    logic       dump_last;

    assign is_full    = (r_fill == FILL_W'(CAPACITY));
    assign is_empty   = (r_fill == '0);
    assign fill_ext   = 9'(r_fill);
    assign pos_ok_ins = (in_pos != '0) && ({1'b0, in_pos} <= fill_ext + 9'd1);
    assign pos_ok_del = (in_pos != '0) && ({1'b0, in_pos} <= fill_ext);
    assign fill_b     = 8'(r_fill);
    assign fill_m1    = fill_b - 8'd1;
    assign pos_m1     = in_pos - 8'd1;
    assign dump_last  = (8'(r_dump_idx) == fill_m1);

    always_comb begin
        n_fill      = r_fill;
        n_dumping   = r_dumping;
        n_dump_idx  = r_dump_idx;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_status    = r_status;
        n_count     = r_count;
        n_value     = r_value;
        n_last      = r_last;
        cell_ctl.op  = pidl_pkg::OP_HOLD;
        cell_ctl.idx = '0;

        if (in_acc) begin
            n_status    = pidl_pkg::ST_OK;
            n_value     = '0;
            n_last      = 1'b1;
            n_out_valid = 1'b1;
            unique case (in_cmd) inside
                pidl_pkg::CMD_INS_FRONT, pidl_pkg::CMD_INS_BACK: begin
                    if (is_full) begin
                        n_status = pidl_pkg::ST_FULL;
                    end else begin
                        cell_ctl.op  = pidl_pkg::OP_INSERT;
                        cell_ctl.idx = (in_cmd == pidl_pkg::CMD_INS_FRONT) ?
                                       '0 : fill_b[IW-1:0];
                        n_fill = r_fill + FILL_W'(1);
                    end
                end
                pidl_pkg::CMD_INS_POS: begin
                    if (!pos_ok_ins) begin
                        n_status = pidl_pkg::ST_BADPOS;
                    end else if (is_full) begin
                        n_status = pidl_pkg::ST_FULL;
                    end else begin
                        cell_ctl.op  = pidl_pkg::OP_INSERT;
                        cell_ctl.idx = pos_m1[IW-1:0];
                        n_fill = r_fill + FILL_W'(1);
                    end
                end
                pidl_pkg::CMD_DEL_FRONT, pidl_pkg::CMD_DEL_BACK: begin
                    if (is_empty) begin
                        n_status = pidl_pkg::ST_EMPTY;
                    end else begin
                        cell_ctl.op  = pidl_pkg::OP_DELETE;
                        cell_ctl.idx = (in_cmd == pidl_pkg::CMD_DEL_FRONT) ?
                                       '0 : fill_m1[IW-1:0];
                        n_fill = r_fill - FILL_W'(1);
                    end
                end
                pidl_pkg::CMD_DEL_POS: begin
                    if (is_empty) begin
                        n_status = pidl_pkg::ST_EMPTY;
                    end else if (!pos_ok_del) begin
                        n_status = pidl_pkg::ST_BADPOS;
                    end else begin
                        cell_ctl.op  = pidl_pkg::OP_DELETE;
                        cell_ctl.idx = pos_m1[IW-1:0];
                        n_fill = r_fill - FILL_W'(1);
                    end
                end
                pidl_pkg::CMD_DUMP: begin
                    if (is_empty) begin
                        n_status = pidl_pkg::ST_EMPTY;
                    end else begin
                        // entries follow one per cycle from the dump state while the output is free
                        n_out_valid = 1'b0;
                        n_dumping   = 1'b1;
                        n_dump_idx  = '0;
                    end
                end
                default: n_status = pidl_pkg::ST_OK;  // unused code: list unchanged, OK result sent
            endcase
            n_count = pidl_pkg::COUNT_W'(n_fill);
        end else if (r_dumping && out_free) begin
            // emit the head and rotate the list by one
            n_out_valid  = 1'b1;
            n_status     = pidl_pkg::ST_OK;
            n_count      = pidl_pkg::COUNT_W'(r_fill);
            n_value      = w_cell[0];
            n_last       = dump_last;
            cell_ctl.op  = pidl_pkg::OP_ROTATE;
            cell_ctl.idx = fill_m1[IW-1:0];
            n_dump_idx   = r_dump_idx + FILL_W'(1);
            if (dump_last) begin
                n_dumping = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_fill      <= '0;
            r_dumping   <= 1'b0;
            r_dump_idx  <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_fill      <= n_fill;
            r_dumping   <= n_dumping;
            r_dump_idx  <= n_dump_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_count  <= n_count;
        r_value  <= n_value;
        r_last   <= n_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_value, r_count};
    assign m_axis_tuser  = r_status;
    assign m_axis_tlast  = r_last;

    `PIDL_ASSERT(a_fill_bound, i_clk, i_rst_n, r_fill <= FILL_W'(CAPACITY), "fill above capacity")
    `PIDL_ASSERT(a_no_take_in_dump, i_clk, i_rst_n, r_dumping |-> !s_axis_tready, "item taken during dump")
    `PIDL_ASSERT(a_fill_only_on_edit, i_clk, i_rst_n, !in_acc |=> $stable(r_fill), "fill moved without an item")
    `PIDL_ASSERT(a_dump_idx_bound, i_clk, i_rst_n, r_dumping |-> (r_dump_idx < r_fill), "dump index past fill")
    `PIDL_ASSERT_NR(a_reset_clears, i_clk, !i_rst_n |=> (!r_out_valid && r_fill == '0 && !r_dumping), "reset left state")

endmodule
`default_nettype wire
